[rtl/core/linear_sieve_moebius_unit_macros.svh]
// Assertion macros shared by the linear sieve Moebius unit.
`ifndef LINEAR_SIEVE_MOEBIUS_UNIT_MACROS_SVH
`define LINEAR_SIEVE_MOEBIUS_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define LSM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LSM_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define LSM_ASSERT(label, clk, rst_n, prop, msg)
`define LSM_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

[rtl/core/lsm_pkg.sv]
// Constants, control word type and microcode table of the linear sieve Moebius unit.
package lsm_pkg;

	localparam int TABLE_SIZE  = 65536;
	localparam int TABLE_AW    = $clog2(TABLE_SIZE);
	localparam int PRIME_SLOTS = 8192;
	localparam int PRIME_AW    = $clog2(PRIME_SLOTS);
	localparam int CNT_W       = PRIME_AW + 1;
	localparam int PROD_W      = 2 * TABLE_AW;

	localparam int QUERY_W  = 16;
	localparam int FACTOR_W = 16;
	localparam int MOEB_W   = 2;
	localparam int RES_W    = FACTOR_W + MOEB_W + 1;
	localparam int OUT_W    = ((RES_W + 7) / 8) * 8;
	localparam int PAD_W    = OUT_W - RES_W;

	localparam logic [MOEB_W-1:0] MOEB_ZERO      = 2'b00;
	localparam logic [MOEB_W-1:0] MOEB_ONE       = 2'b01;
	localparam logic [MOEB_W-1:0] MOEB_MINUS_ONE = 2'b11;

	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_CLR   = 4'd0;
	localparam step_t STEP_IDLE  = 4'd1;
	localparam step_t STEP_CHECK = 4'd2;
	localparam step_t STEP_TOP   = 4'd3;
	localparam step_t STEP_NREAD = 4'd4;
	localparam step_t STEP_NDEC  = 4'd5;
	localparam step_t STEP_MREQ  = 4'd6;
	localparam step_t STEP_MMUL  = 4'd7;
	localparam step_t STEP_MCHK  = 4'd8;
	localparam step_t STEP_MWR   = 4'd9;
	localparam step_t STEP_QREAD = 4'd10;
	localparam step_t STEP_QOUT  = 4'd11;
	localparam step_t STEP_LAST  = STEP_QOUT;

	typedef enum logic [3:0] {
		COND_NONE,
		COND_ALWAYS,
		COND_NO_INPUT,
		COND_QBAD,
		COND_LIM_DONE,
		COND_K_END,
		COND_STOP,
		COND_OUT_BUSY,
		COND_CLR_MORE
	} cond_t;

	typedef struct packed {
		cond_t cond;
		step_t target;
		logic  clr;
		logic  acc;
		logic  adv;
		logic  rd_en;
		logic  rd_query;
		logic  ndec;
		logic  prd;
		logic  mul;
		logic  mark;
		logic  ld_out;
	} ctrl_t;

	function automatic ctrl_t ctrl_rom(input step_t step);
		ctrl_t c;
		c = '{cond: COND_NONE, target: STEP_IDLE, default: 1'b0};
		unique case (step)
			STEP_CLR: begin
				c.cond = COND_CLR_MORE;
				c.target = STEP_CLR;
				c.clr = 1'b1;
			end
			STEP_IDLE: begin
				c.cond = COND_NO_INPUT;
				c.target = STEP_IDLE;
				c.acc = 1'b1;
			end
			STEP_CHECK: begin
				c.cond = COND_QBAD;
				c.target = STEP_QOUT;
			end
			STEP_TOP: begin
				c.cond = COND_LIM_DONE;
				c.target = STEP_QREAD;
				c.adv = 1'b1;
			end
			STEP_NREAD: begin
				c.rd_en = 1'b1;
			end
			STEP_NDEC: begin
				c.ndec = 1'b1;
			end
			STEP_MREQ: begin
				c.cond = COND_K_END;
				c.target = STEP_TOP;
				c.prd = 1'b1;
			end
			STEP_MMUL: begin
				c.mul = 1'b1;
			end
			STEP_MCHK: begin
				c.cond = COND_STOP;
				c.target = STEP_TOP;
			end
			STEP_MWR: begin
				c.cond = COND_ALWAYS;
				c.target = STEP_MREQ;
				c.mark = 1'b1;
			end
			STEP_QREAD: begin
				c.rd_en = 1'b1;
				c.rd_query = 1'b1;
			end
			STEP_QOUT: begin
				c.cond = COND_OUT_BUSY;
				c.target = STEP_QOUT;
				c.ld_out = 1'b1;
			end
			default: begin
				c.cond = COND_ALWAYS;
				c.target = STEP_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

[rtl/core/linear_sieve_moebius_unit.sv]
// Top level of the lazy linear sieve unit: smallest prime factor, Moebius value and primality.
// After reset the unit clears its factor and Moebius tables, one entry per cycle, through all
// 65536 entries (TABLE_SIZE), and takes no query until that pass ends. A query for a number
// already sieved passes the check, top, read and output steps to the result register, a query
// for zero jumps from check to output, and the next query can be accepted at the following
// edge. A query above the highest sieved number first extends the sieve number by number: each
// new number takes the top, read and decide steps, the request, multiply, check and write steps
// for each multiple that it marks, and ends its marking loop at the request or check step, in a
// microcoded loop around the single-port factor table and prime list. The result register lets
// the next query be accepted while a result waits to be taken.
`include "linear_sieve_moebius_unit_macros.svh"

module linear_sieve_moebius_unit
	import lsm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [QUERY_W-1:0] s_axis_tdata,  // [15:0] query_number
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [OUT_W-1:0]   m_axis_tdata   // [15:0] smallest_factor, [17:16] moebius_value,
	                                          // [18] number_is_prime, [23:19] zero
);

	logic [FACTOR_W-1:0] fmem [TABLE_SIZE];
	logic [MOEB_W-1:0]   mmem [TABLE_SIZE];
	logic [TABLE_AW-1:0] plist [PRIME_SLOTS];

	step_t               pc_q;
	ctrl_t               ctrl;
	logic                jump;
	logic [TABLE_AW-1:0] clr_q;
	logic [TABLE_AW-1:0] lim_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    k_q;
	logic                out_valid_q;

	logic [QUERY_W-1:0]       q_q;
	logic [TABLE_AW-1:0]      n_q;
	logic [TABLE_AW-1:0]      f_q;
	logic signed [MOEB_W-1:0] mu_q;
	logic [TABLE_AW-1:0]      pr_q;
	logic [PROD_W-1:0]        prod_q;
	logic [FACTOR_W-1:0]      rd_f_q;
	logic [MOEB_W-1:0]        rd_m_q;
	logic [TABLE_AW-1:0]      pl_rd_q;
	logic [FACTOR_W-1:0]      out_f_q;
	logic [MOEB_W-1:0]        out_m_q;
	logic                     out_p_q;

	logic                qbad;
	logic                out_busy;
	logic                is_new;
	logic                append;
	logic                adv_do;
	logic                ld_do;
	logic                accept;
	logic                we;
	logic [TABLE_AW-1:0] wa;
	logic [FACTOR_W-1:0] wf;
	logic [MOEB_W-1:0]   wm;
	logic [TABLE_AW-1:0] ra;

	assign ctrl     = ctrl_rom(pc_q);
	assign qbad     = (q_q == '0) || (32'(q_q) >= 32'(TABLE_SIZE));
	assign out_busy = out_valid_q && !m_axis_tready;
	assign is_new   = (rd_f_q == '0);
	assign append   = ctrl.ndec && is_new && (cnt_q < CNT_W'(PRIME_SLOTS));
	assign accept   = s_axis_tvalid && s_axis_tready;

	always_comb begin
		unique case (ctrl.cond)
			COND_NONE:     jump = 1'b0;
			COND_ALWAYS:   jump = 1'b1;
			COND_NO_INPUT: jump = !s_axis_tvalid;
			COND_QBAD:     jump = qbad;
			COND_LIM_DONE: jump = (32'(lim_q) >= 32'(q_q));
			COND_K_END:    jump = (k_q >= cnt_q);
			COND_STOP:     jump = (pr_q > f_q) || (prod_q[PROD_W-1:TABLE_AW] != '0);
			COND_OUT_BUSY: jump = out_busy;
			COND_CLR_MORE: jump = (clr_q != TABLE_AW'(TABLE_SIZE - 1));
			default:       jump = 1'b0;
		endcase
	end

	assign adv_do        = ctrl.adv && !jump;
	assign ld_do         = ctrl.ld_out && !jump;
	assign s_axis_tready = ctrl.acc;

	always_comb begin
		we = 1'b0;
		wa = n_q;
		wf = FACTOR_W'(n_q);
		wm = MOEB_MINUS_ONE;
		if (ctrl.clr) begin
			we = 1'b1;
			wa = clr_q;
			wf = '0;
			wm = (clr_q == TABLE_AW'(1)) ? MOEB_ONE : MOEB_ZERO;
		end else if (ctrl.ndec && is_new) begin
			we = 1'b1;
		end else if (ctrl.mark) begin
			we = 1'b1;
			wa = prod_q[TABLE_AW-1:0];
			wf = FACTOR_W'(pr_q);
			wm = (pr_q == f_q) ? MOEB_ZERO : -mu_q;
		end
	end

	assign ra = ctrl.rd_query ? TABLE_AW'(q_q) : n_q;

	always_ff @(posedge clk) begin
		if (we) begin
			fmem[wa] <= wf;
			mmem[wa] <= wm;
		end
		if (ctrl.rd_en) begin
			rd_f_q <= fmem[ra];
			rd_m_q <= mmem[ra];
		end
	end

	always_ff @(posedge clk) begin
		if (append) begin
			plist[cnt_q[PRIME_AW-1:0]] <= n_q;
		end
		if (ctrl.prd) begin
			pl_rd_q <= plist[k_q[PRIME_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= STEP_CLR;
			clr_q       <= '0;
			lim_q       <= TABLE_AW'(1);
			cnt_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (jump) begin
				pc_q <= ctrl.target;
			end else if (pc_q == STEP_LAST) begin
				pc_q <= STEP_IDLE;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
			if (ctrl.clr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (adv_do) begin
				lim_q <= lim_q + 1'b1;
			end
			if (append) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (ctrl.ndec) begin
				k_q <= '0;
			end else if (ctrl.mark) begin
				k_q <= k_q + 1'b1;
			end
			if (ld_do) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_q <= s_axis_tdata;
		end
		if (adv_do) begin
			n_q <= lim_q + 1'b1;
		end
		if (ctrl.ndec) begin
			f_q  <= is_new ? n_q : TABLE_AW'(rd_f_q);
			mu_q <= is_new ? MOEB_MINUS_ONE : rd_m_q;
		end
		if (ctrl.mul) begin
			pr_q   <= pl_rd_q;
			prod_q <= PROD_W'(pl_rd_q) * PROD_W'(n_q);
		end
		if (ld_do) begin
			out_f_q <= qbad ? '0 : rd_f_q;
			out_m_q <= qbad ? MOEB_ZERO : rd_m_q;
			out_p_q <= !qbad && (q_q >= QUERY_W'(2)) && (32'(rd_f_q) == 32'(q_q));
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {PAD_W'(0), out_p_q, out_m_q, out_f_q};

	// A number under decision is always the newest sieved number.
	`LSM_ASSERT(a_ndec_is_limit, clk, arst_n, (pc_q == STEP_NDEC) |-> (lim_q == n_q),
		"decided number differs from sieve limit")
	// Marks come only from primes not above the smallest factor and stay inside the table.
	`LSM_ASSERT(a_mark_legal, clk, arst_n,
		(pc_q == STEP_MWR) |-> ((pr_q <= f_q) && (prod_q[PROD_W-1:TABLE_AW] == '0)),
		"illegal mark write")
	// The marking index never runs past the prime count.
	`LSM_ASSERT_NEVER(a_k_in_range, clk, arst_n, (k_q > cnt_q), "prime index beyond prime count")
	// Every sieved number ends up with a nonzero smallest factor.
	`LSM_ASSERT(a_factor_set, clk, arst_n, (pc_q == STEP_NDEC) |=> (f_q != '0),
		"sieved number without factor")

endmodule

[test/tb_linear_sieve_moebius_unit.sv]
// Self-checking testbench that streams number queries into the linear sieve unit.
module tb_linear_sieve_moebius_unit
	import lsm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [FACTOR_W-1:0] factor;
		logic [MOEB_W-1:0]   moebius;
		logic                prime;
	} sieve_answer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [QUERY_W-1:0] s_axis_tdata = '0;  // [15:0] query_number
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [OUT_W-1:0]   m_axis_tdata;       // [15:0] smallest_factor, [17:16] moebius_value,
	                                        // [18] number_is_prime, [23:19] zero

	int unsigned spf_tbl [TABLE_SIZE];
	int          mu_tbl [TABLE_SIZE];
	int unsigned primes [PRIME_SLOTS];
	int unsigned n_primes;
	int unsigned sieve_top;

	logic [QUERY_W-1:0] pending_queries[$];
	sieve_answer_t      expected_answers[$];
	int unsigned        opening_queries[$] = '{1, 0, 2, 3, 4, 5, 6, 7, 8, 9, 12, 30, 25, 27,
		210, 2310, 2, 1, 0, 2309, 2311, 4096};

	sieve_answer_t got_answer;
	sieve_answer_t want_answer;
	int            n_items;
	int            queries_taken = 0;
	int            queries_seen = 0;
	int            errors = 0;
	logic          item_held = 1'b0;
	int            in_gap = 0;
	int            in_calm = 0;
	int            out_hold = 0;
	int            out_calm = 0;
	int            out_pick;

	linear_sieve_moebius_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	function automatic void sieve_number(int unsigned n);
		int unsigned     f;
		int unsigned     c;
		int unsigned     k;
		longint unsigned prod;
		if (spf_tbl[n] == 0) begin
			spf_tbl[n] = n;
			if (n_primes < PRIME_SLOTS) begin
				primes[n_primes] = n;
				n_primes++;
			end
		end
		f = spf_tbl[n];
		c = n / f;
		if (spf_tbl[c] == f) begin
			mu_tbl[n] = 0;
		end else begin
			mu_tbl[n] = -mu_tbl[c];
		end
		for (k = 0; k < n_primes; k++) begin
			prod = longint'(primes[k]) * longint'(n);
			if (primes[k] > f || prod >= TABLE_SIZE) break;
			spf_tbl[int'(prod)] = primes[k];
		end
	endfunction

	function automatic sieve_answer_t answer_query(logic [QUERY_W-1:0] q);
		sieve_answer_t a;
		int unsigned   qn;
		a = '0;
		qn = q;
		if (qn == 0 || qn >= TABLE_SIZE) return a;
		while (sieve_top < qn) begin
			sieve_top++;
			sieve_number(sieve_top);
		end
		a.factor = FACTOR_W'(spf_tbl[qn]);
		case (mu_tbl[qn])
			1: a.moebius = MOEB_ONE;
			-1: a.moebius = MOEB_MINUS_ONE;
			default: a.moebius = MOEB_ZERO;
		endcase
		a.prime = (qn >= 2 && spf_tbl[qn] == qn);
		return a;
	endfunction

	task automatic pick_gap(inout int calm, output int len);
		int r;
		r = $urandom_range(0, 99);
		if (calm > 0) begin
			calm--;
			len = 0;
		end else if (r < 3) begin
			calm = $urandom_range(20, 80);
			len = 0;
		end else if (r < 55) begin
			len = 0;
		end else if (r < 85) begin
			len = $urandom_range(1, 3);
		end else if (r < 97) begin
			len = $urandom_range(4, 12);
		end else begin
			len = $urandom_range(20, 60);
		end
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("TB_ERROR");
		$finish;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && queries_taken != queries_seen) begin
				queries_seen = queries_taken;
				item_held = 1'b0;
			end
			if (!item_held) begin
				if (in_gap > 0) begin
					in_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_queries.size() > 0) begin
					s_axis_tdata <= pending_queries.pop_front();
					s_axis_tvalid <= 1'b1;
					item_held = 1'b1;
					pick_gap(in_calm, in_gap);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			if (out_hold > 0) begin
				out_hold--;
				m_axis_tready <= 1'b0;
			end else begin
				pick_gap(out_calm, out_pick);
				if (out_pick == 0) begin
					m_axis_tready <= 1'b1;
				end else begin
					m_axis_tready <= 1'b0;
					out_hold = out_pick - 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_answers = {expected_answers, answer_query(s_axis_tdata)};
				queries_taken++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got_answer.factor = m_axis_tdata[FACTOR_W-1:0];
				got_answer.moebius = m_axis_tdata[FACTOR_W +: MOEB_W];
				got_answer.prime = m_axis_tdata[FACTOR_W + MOEB_W];
				if (expected_answers.size() == 0) begin
					$error("unexpected result transaction: data %h", m_axis_tdata);
					errors++;
				end else begin
					want_answer = expected_answers.pop_front();
					if (got_answer.factor !== want_answer.factor) begin
						$error("smallest_factor mismatch: expected %0d, actual %0d",
							want_answer.factor, got_answer.factor);
						errors++;
					end
					if (got_answer.moebius !== want_answer.moebius) begin
						$error("moebius_value mismatch: expected %0d, actual %0d",
							$signed(want_answer.moebius), $signed(got_answer.moebius));
						errors++;
					end
					if (got_answer.prime !== want_answer.prime) begin
						$error("number_is_prime mismatch: expected %0d, actual %0d",
							want_answer.prime, got_answer.prime);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		int unsigned frontier;
		int unsigned q;
		int unsigned r;
		int          i;
		for (i = 0; i < TABLE_SIZE; i++) begin
			spf_tbl[i] = 0;
			mu_tbl[i] = 0;
		end
		mu_tbl[1] = 1;
		n_primes = 0;
		sieve_top = 1;

		frontier = 1;
		foreach (opening_queries[j]) begin
			pending_queries = {pending_queries, QUERY_W'(opening_queries[j])};
			if (opening_queries[j] > frontier) frontier = opening_queries[j];
		end
		// Most random queries either reread sieved numbers or push the sieve a little further.
		for (i = 0; i < 1200; i++) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				q = $urandom_range(0, 65535);
			end else if (r < 8) begin
				q = 0;
			end else if (r < 35) begin
				q = frontier + $urandom_range(1, 64);
				if (q > 65535) q = 65535;
			end else begin
				q = $urandom_range(1, frontier);
			end
			if (q > frontier) frontier = q;
			pending_queries = {pending_queries, QUERY_W'(q)};
		end
		pending_queries = {pending_queries, QUERY_W'(65521)};
		pending_queries = {pending_queries, QUERY_W'(65535)};
		pending_queries = {pending_queries, QUERY_W'(65534)};
		pending_queries = {pending_queries, QUERY_W'(0)};
		n_items = pending_queries.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (queries_taken != n_items) @(posedge clk);
		while (expected_answers.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/lsm_pkg.sv
rtl/core/linear_sieve_moebius_unit.sv
test/tb_linear_sieve_moebius_unit.sv
